// ===== rtl/wep_pkg.sv =====
// shared constants, codes and types of the window extremum locator
`default_nettype none

package wep_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_SAMPLES = 4096;
    localparam int COUNT_BITS  = $clog2(MAX_SAMPLES + 1);
    localparam int POS_BITS    = 21;
    localparam int LEN_BITS    = 13;
    localparam int FRAC_BITS   = 8;
    localparam int MODE_BITS   = 2;

    // refinement datapath widths
    localparam int DIFF_BITS     = SAMPLE_BITS + 1;
    localparam int DEN_BITS      = SAMPLE_BITS + 3;
    localparam int NUM_MAG_BITS  = DIFF_BITS + FRAC_BITS - 1;
    localparam int DIVIDEND_BITS = NUM_MAG_BITS + 2;
    localparam int DIVISOR_BITS  = SAMPLE_BITS + 3;
    localparam int QUOT_BITS     = FRAC_BITS + 1;
    localparam int SHIFT_BITS    = DIVISOR_BITS + QUOT_BITS - 1;
    localparam int DIV_STEPS     = QUOT_BITS;
    localparam int STEP_BITS     = $clog2(DIV_STEPS);

    localparam logic [MODE_BITS-1:0] MODE_BOTH = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_MAX  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_MIN  = 2'd2;

    typedef enum logic [1:0] {
        S_TRACK,
        S_LOCATE,
        S_DIVIDE,
        S_EMIT
    } wep_state_t;

    typedef struct packed {
        logic track;
        logic locate;
        logic div_step;
        logic emit;
    } wep_cmd_t;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } wep_status_t;

endpackage

`default_nettype wire

// ===== rtl/wep_in_if.sv =====
// sample channel: valid, ready and one sample of the window
`default_nettype none

interface wep_in_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [wep_pkg::SAMPLE_BITS-1:0]    sample_value;
    logic                                      last_sample;

    modport source (output valid, output sample_value, output last_sample, input ready);
    modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/wep_out_if.sv =====
// result channel: valid, ready, refined position and window length
`default_nettype none

interface wep_out_if;
    logic                             valid;
    logic                             ready;
    logic [wep_pkg::POS_BITS-1:0]     position_q8;
    logic [wep_pkg::LEN_BITS-1:0]     window_length;

    modport source (output valid, output position_q8, output window_length, input ready);
    modport sink   (input valid, input position_q8, input window_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/wep_datapath.sv =====
// extremum tracking, special-case selection, restoring divider and output register
`default_nettype none

module wep_datapath (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [wep_pkg::MODE_BITS-1:0]          cfg_wr_data,
    input  wire logic signed [wep_pkg::SAMPLE_BITS-1:0] sample_value,
    input  wire wep_pkg::wep_cmd_t                      cmd,
    output wep_pkg::wep_status_t                        status,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [wep_pkg::POS_BITS-1:0]                position_q8,
    output logic [wep_pkg::LEN_BITS-1:0]                window_length
);

    localparam int SB = wep_pkg::SAMPLE_BITS;
    localparam int CB = wep_pkg::COUNT_BITS;
    localparam int PB = wep_pkg::POS_BITS;

    // window state
    logic [wep_pkg::MODE_BITS-1:0] mode_reg, mode_next;
    logic [CB-1:0]         count_reg, count_next;
    logic signed [SB-1:0]  min_reg, min_next, max_reg, max_next;
    logic [CB-1:0]         min_idx_reg, min_idx_next, max_idx_reg, max_idx_next;
    logic signed [SB-1:0]  lmin_reg, lmin_next, rmin_reg, rmin_next;
    logic signed [SB-1:0]  lmax_reg, lmax_next, rmax_reg, rmax_next;
    logic signed [SB-1:0]  prev_reg, prev_next, first_reg, first_next;
    logic [1:0]            await_reg, await_next;

    // divider and output state
    logic [PB-1:0]                          base_reg, base_next;
    logic                                   neg_reg, neg_next;
    logic [wep_pkg::DIVIDEND_BITS-1:0]      rem_reg, rem_next;
    logic [wep_pkg::SHIFT_BITS-1:0]         dsh_reg, dsh_next;
    logic [wep_pkg::QUOT_BITS-1:0]          quot_reg, quot_next;
    logic                                   out_valid_reg, out_valid_next;
    logic [PB-1:0]                          pos_reg, pos_next;
    logic [wep_pkg::LEN_BITS-1:0]           len_reg, len_next;

    // locate logic
    logic [wep_pkg::MODE_BITS-1:0]          eff_mode;
    logic signed [SB:0]                     map_first, map_prev;
    logic [SB:0]                            abs_min, abs_max;
    logic [CB-1:0]                          idx;
    logic                                   sel_min;
    logic signed [SB-1:0]                   lv, cv, rv;
    logic signed [wep_pkg::DIFF_BITS-1:0]   diff;
    logic signed [wep_pkg::DEN_BITS-1:0]    den;
    logic [wep_pkg::DIFF_BITS-1:0]          diff_mag;
    logic [wep_pkg::DEN_BITS-1:0]           den_mag;
    logic [wep_pkg::DIVIDEND_BITS-1:0]      dividend;
    logic [wep_pkg::DIVISOR_BITS-1:0]       divisor;
    logic [PB-1:0]                          base;
    logic [PB-1:0]                          idx_pos;
    logic                                   need_div;
    logic [wep_pkg::SHIFT_BITS-1:0]         rem_ext;
    logic                                   at_limit;

    function automatic logic signed [SB:0] mode_map(
        input logic [wep_pkg::MODE_BITS-1:0] m,
        input logic signed [SB-1:0]          v
    );
        logic signed [SB:0] w;
        begin
            w = (SB + 1)'(v);
            case (m)
                wep_pkg::MODE_MAX: mode_map = w;
                wep_pkg::MODE_MIN: mode_map = -w;
                default:           mode_map = (w < 0) ? -w : w;
            endcase
        end
    endfunction

    // ---------------- tracking ----------------
    assign at_limit = (count_reg >= CB'(wep_pkg::MAX_SAMPLES));

    always_comb
    begin
        mode_next    = cfg_wr_en ? cfg_wr_data : mode_reg;
        count_next   = count_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        min_idx_next = min_idx_reg;
        max_idx_next = max_idx_reg;
        lmin_next    = lmin_reg;
        rmin_next    = rmin_reg;
        lmax_next    = lmax_reg;
        rmax_next    = rmax_reg;
        prev_next    = prev_reg;
        first_next   = first_reg;
        await_next   = await_reg;
        if (cmd.track && !at_limit)
        begin
            count_next = count_reg + CB'(1);
            prev_next  = sample_value;
            if (count_reg == '0)
            begin
                min_next     = sample_value;
                max_next     = sample_value;
                min_idx_next = CB'(1);
                max_idx_next = CB'(1);
                first_next   = sample_value;
                await_next   = 2'b00;
            end
            else
            begin
                if (await_reg[0])
                begin
                    rmin_next = sample_value;
                end
                if (await_reg[1])
                begin
                    rmax_next = sample_value;
                end
                await_next = 2'b00;
                if (sample_value < min_reg)
                begin
                    min_next      = sample_value;
                    min_idx_next  = count_reg + CB'(1);
                    lmin_next     = prev_reg;
                    await_next[0] = 1'b1;
                end
                if (sample_value > max_reg)
                begin
                    max_next      = sample_value;
                    max_idx_next  = count_reg + CB'(1);
                    lmax_next     = prev_reg;
                    await_next[1] = 1'b1;
                end
            end
        end
        if (cmd.emit)
        begin
            count_next = '0;
            await_next = 2'b00;
        end
    end

    // ---------------- locate ----------------
    always_comb
    begin
        case (mode_reg)
            wep_pkg::MODE_MAX: eff_mode = wep_pkg::MODE_MAX;
            wep_pkg::MODE_MIN: eff_mode = wep_pkg::MODE_MIN;
            default:           eff_mode = wep_pkg::MODE_BOTH;
        endcase
    end

    assign map_first = mode_map(eff_mode, first_reg);
    assign map_prev  = mode_map(eff_mode, prev_reg);
    assign abs_min   = (min_reg < 0) ? (SB + 1)'(-(SB + 1)'(min_reg)) : (SB + 1)'(min_reg);
    assign abs_max   = (max_reg < 0) ? (SB + 1)'(-(SB + 1)'(max_reg)) : (SB + 1)'(max_reg);

    always_comb
    begin
        case (eff_mode)
            wep_pkg::MODE_MAX: idx = max_idx_reg;
            wep_pkg::MODE_MIN: idx = min_idx_reg;
            default:           idx = (abs_min > abs_max) ? min_idx_reg : max_idx_reg;
        endcase
    end

    assign sel_min = (idx == min_idx_reg)
                  && ((eff_mode == wep_pkg::MODE_MIN) || (idx != max_idx_reg));
    assign lv = sel_min ? lmin_reg : lmax_reg;
    assign cv = sel_min ? min_reg  : max_reg;
    assign rv = sel_min ? rmin_reg : rmax_reg;

    assign diff = wep_pkg::DIFF_BITS'(rv) - wep_pkg::DIFF_BITS'(lv);
    assign den  = (wep_pkg::DEN_BITS'(cv) <<< 1) - wep_pkg::DEN_BITS'(lv)
                - wep_pkg::DEN_BITS'(rv);
    assign diff_mag = (diff < 0) ? wep_pkg::DIFF_BITS'(-diff) : wep_pkg::DIFF_BITS'(diff);
    assign den_mag  = (den < 0) ? wep_pkg::DEN_BITS'(-den) : wep_pkg::DEN_BITS'(den);

    // q = (2*|num| + |den|) / (2*|den|), num = 128*(r-l)
    assign dividend = (wep_pkg::DIVIDEND_BITS'(diff_mag) << wep_pkg::FRAC_BITS)
                    + wep_pkg::DIVIDEND_BITS'(den_mag);
    assign divisor  = wep_pkg::DIVISOR_BITS'(den_mag) << 1;

    assign idx_pos = PB'(idx) << wep_pkg::FRAC_BITS;

    always_comb
    begin
        need_div = 1'b0;
        base     = idx_pos;
        if (count_reg <= CB'(1))
        begin
            base = PB'(1) << wep_pkg::FRAC_BITS;
        end
        else if (count_reg == CB'(2))
        begin
            if (map_first > map_prev)
            begin
                base = PB'(1) << wep_pkg::FRAC_BITS;
            end
            else if (map_first < map_prev)
            begin
                base = PB'(2) << wep_pkg::FRAC_BITS;
            end
            else
            begin
                base = PB'(3) << (wep_pkg::FRAC_BITS - 1);
            end
        end
        else if (min_reg == max_reg)
        begin
            // flat window: midpoint
            base = PB'({1'b0, count_reg} + (CB + 1)'(1)) << (wep_pkg::FRAC_BITS - 1);
        end
        else if ((idx <= CB'(1)) || (idx >= count_reg))
        begin
            base = idx_pos;
        end
        else
        begin
            need_div = (den != '0);
        end
    end

    // ---------------- divider and output ----------------
    assign rem_ext = wep_pkg::SHIFT_BITS'(rem_reg);

    always_comb
    begin
        base_next = base_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        if (cmd.locate)
        begin
            base_next = base;
            neg_next  = (diff < 0) ^ (den < 0);
            rem_next  = dividend;
            dsh_next  = wep_pkg::SHIFT_BITS'(divisor) << (wep_pkg::QUOT_BITS - 1);
            quot_next = '0;
        end
        else if (cmd.div_step)
        begin
            dsh_next = dsh_reg >> 1;
            if (rem_ext >= dsh_reg)
            begin
                rem_next  = wep_pkg::DIVIDEND_BITS'(rem_ext - dsh_reg);
                quot_next = {quot_reg[wep_pkg::QUOT_BITS-2:0], 1'b1};
            end
            else
            begin
                quot_next = {quot_reg[wep_pkg::QUOT_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            pos_next       = neg_reg ? (base_reg - PB'(quot_reg)) : (base_reg + PB'(quot_reg));
            len_next       = wep_pkg::LEN_BITS'(count_reg);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= wep_pkg::MODE_BOTH;
            count_reg     <= '0;
            await_reg     <= 2'b00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            await_reg     <= await_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg     <= min_next;
        max_reg     <= max_next;
        min_idx_reg <= min_idx_next;
        max_idx_reg <= max_idx_next;
        lmin_reg    <= lmin_next;
        rmin_reg    <= rmin_next;
        lmax_reg    <= lmax_next;
        rmax_reg    <= rmax_next;
        prev_reg    <= prev_next;
        first_reg   <= first_next;
        base_reg    <= base_next;
        neg_reg     <= neg_next;
        rem_reg     <= rem_next;
        dsh_reg     <= dsh_next;
        quot_reg    <= quot_next;
        pos_reg     <= pos_next;
        len_reg     <= len_next;
    end

    assign status.need_div = need_div;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign position_q8     = pos_reg;
    assign window_length   = len_reg;

endmodule

`default_nettype wire

// ===== rtl/wep_controller.sv =====
// sequencer: sample tracking, locate, divider steps and result hand-off
`default_nettype none

module wep_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_last,
    output logic                      in_ready,
    input  wire wep_pkg::wep_status_t status,
    output wep_pkg::wep_cmd_t         cmd
);

    wep_pkg::wep_state_t               state_reg, state_next;
    logic [wep_pkg::STEP_BITS-1:0]     step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            wep_pkg::S_TRACK:
            begin
                if (in_valid && in_last)
                begin
                    state_next = wep_pkg::S_LOCATE;
                end
            end
            wep_pkg::S_LOCATE:
            begin
                step_next  = wep_pkg::STEP_BITS'(wep_pkg::DIV_STEPS - 1);
                state_next = status.need_div ? wep_pkg::S_DIVIDE : wep_pkg::S_EMIT;
            end
            wep_pkg::S_DIVIDE:
            begin
                step_next = step_reg - wep_pkg::STEP_BITS'(1);
                if (step_reg == '0)
                begin
                    state_next = wep_pkg::S_EMIT;
                end
            end
            wep_pkg::S_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = wep_pkg::S_TRACK;
                end
            end
            default:
            begin
                state_next = wep_pkg::S_TRACK;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.track    = 1'b0;
        cmd.locate   = 1'b0;
        cmd.div_step = 1'b0;
        cmd.emit     = 1'b0;
        case (state_reg)
            wep_pkg::S_TRACK:
            begin
                in_ready  = 1'b1;
                cmd.track = in_valid;
            end
            wep_pkg::S_LOCATE:
            begin
                cmd.locate = 1'b1;
            end
            wep_pkg::S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            wep_pkg::S_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wep_pkg::S_TRACK;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/window_extremum_parabolic.sv =====
// top level of the window extremum locator
`default_nettype none

// Takes one signed sample per transaction and tracks the first minimum and first
// maximum of the window with their neighbours. Non-final samples are taken one per
// cycle. The final sample (last_sample set) is followed by the locate state, then,
// only when the position is refined by parabolic interpolation, the restoring
// divider (one quotient bit per cycle), then the emit state, which waits for a free
// output register, loads it and clears the window; the next window's first sample
// is taken after that. The result waits in the output register while the next
// window runs; a new result waits for it to be taken. The mode on cfg_wr_data
// selects both extrema by larger magnitude (0, also 3), maxima (1) or minima (2);
// write it only between windows. Samples beyond 4096 in a window are ignored.
module window_extremum_parabolic (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [wep_pkg::MODE_BITS-1:0]      cfg_wr_data,
    wep_in_if.sink                                  in_ch,
    wep_out_if.source                               out_ch
);

    wep_pkg::wep_cmd_t    cmd;
    wep_pkg::wep_status_t status;

    wep_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_last  (in_ch.last_sample),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    wep_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .sample_value  (in_ch.sample_value),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .position_q8   (out_ch.position_q8),
        .window_length (out_ch.window_length)
    );

endmodule

`default_nettype wire
